// File: sv/bbst_pkg.sv
// Package for the bracket balance segment tree unit.
// Holds the item types, command codes and controller/datapath interface structs.
// No dependencies.
package bbst_pkg;

    localparam int POS_W   = 11;
    localparam int COUNT_W = 11;

    localparam logic CMD_SET    = 1'b0;
    localparam logic CMD_FLIP   = 1'b1;
    localparam logic KIND_OPEN  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [POS_W-1:0] position;
        logic             bracket_kind;
    } in_item_t;

    typedef struct packed {
        logic               balanced;
        logic [COUNT_W-1:0] unmatched_open;
        logic [COUNT_W-1:0] unmatched_close;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic clear_wr;
        logic leaf_rd;
        logic leaf_wr;
        logic sib_rd;
        logic merge_wr;
        logic load_result;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic pos_ok;
        logic at_top;
    } dp_status_t;

endpackage

// File: sv/bbst_ctrl.sv
// Controller for the bracket balance segment tree unit.
// Sequences the clearing pass, the leaf update and the level walk to the root.
// Depends on bbst_pkg.
module bbst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bbst_pkg::dp_status_t status,
    output bbst_pkg::dp_cmd_t    cmd
);
    import bbst_pkg::*;

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_LEAF_RD = 3'd2;
    localparam logic [2:0] S_LEAF_WR = 3'd3;
    localparam logic [2:0] S_SIB_RD  = 3'd4;
    localparam logic [2:0] S_MERGE   = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.pos_ok ? S_LEAF_RD : S_DONE;
                end
            end
            S_LEAF_RD:
            begin
                cmd.leaf_rd = 1'b1;
                state_next  = S_LEAF_WR;
            end
            S_LEAF_WR:
            begin
                cmd.leaf_wr = 1'b1;
                state_next  = S_SIB_RD;
            end
            S_SIB_RD:
            begin
                cmd.sib_rd = 1'b1;
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                cmd.merge_wr = 1'b1;
                state_next   = status.at_top ? S_DONE : S_SIB_RD;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/bbst_dpath.sv
// Datapath for the bracket balance segment tree unit.
// Holds the node memory, the walk index, the running node value, root and result registers.
// Depends on bbst_pkg.
module bbst_dpath #(
    parameter int LEAVES = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bbst_pkg::in_item_t   in_data,
    input  bbst_pkg::dp_cmd_t    cmd,
    output bbst_pkg::dp_status_t status,
    output bbst_pkg::out_item_t  out_data
);
    import bbst_pkg::*;

    localparam int SPAN_LOG = $clog2(LEAVES);
    localparam int AW       = SPAN_LOG + 1;
    localparam int DEPTH    = 2 ** AW;
    localparam int CW       = $clog2(LEAVES + 1);

    logic [2*CW-1:0] mem [DEPTH];
    logic [2*CW-1:0] rd_data_reg;

    in_item_t        item_reg;
    logic [AW-1:0]   idx_reg;
    logic [AW-1:0]   clr_cnt_reg;
    logic [CW-1:0]   cur_open_reg;
    logic [CW-1:0]   cur_close_reg;
    logic [CW-1:0]   root_open_reg;
    logic [CW-1:0]   root_close_reg;
    out_item_t       result_reg;

    logic [POS_W-1:0]          pos_m1;
    logic [SPAN_LOG+POS_W-1:0] pos_ext;
    logic [AW-1:0]             leaf_idx;
    logic [AW-1:0]             parent_idx;
    logic [CW-1:0]             rd_open;
    logic [CW-1:0]             rd_close;
    logic [CW-1:0]             leaf_open;
    logic [CW-1:0]             leaf_close;
    logic [CW-1:0]             l_open;
    logic [CW-1:0]             l_close;
    logic [CW-1:0]             r_open;
    logic [CW-1:0]             r_close;
    logic [CW-1:0]             match;
    logic [CW-1:0]             p_open;
    logic [CW-1:0]             p_close;
    logic                      mem_we;
    logic [AW-1:0]             mem_wa;
    logic [2*CW-1:0]           mem_wd;
    logic [AW-1:0]             mem_ra;

    assign pos_m1     = in_data.position - POS_W'(1);
    assign pos_ext    = {{SPAN_LOG{1'b0}}, pos_m1};
    assign leaf_idx   = {1'b1, pos_ext[SPAN_LOG-1:0]};
    assign parent_idx = {1'b0, idx_reg[AW-1:1]};

    assign status.pos_ok     = (in_data.position != '0) && (32'(in_data.position) <= LEAVES);
    assign status.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));
    assign status.at_top     = (parent_idx == AW'(1));

    assign rd_open  = rd_data_reg[2*CW-1:CW];
    assign rd_close = rd_data_reg[CW-1:0];

    always_comb
    begin
        if (item_reg.cmd == CMD_SET)
        begin
            leaf_open  = (item_reg.bracket_kind == KIND_OPEN)  ? CW'(1) : '0;
            leaf_close = (item_reg.bracket_kind == KIND_CLOSE) ? CW'(1) : '0;
        end
        else
        begin
            leaf_open  = rd_close;
            leaf_close = rd_open;
        end
    end

    always_comb
    begin
        if (idx_reg[0] == 1'b0)
        begin
            l_open  = cur_open_reg;
            l_close = cur_close_reg;
            r_open  = rd_open;
            r_close = rd_close;
        end
        else
        begin
            l_open  = rd_open;
            l_close = rd_close;
            r_open  = cur_open_reg;
            r_close = cur_close_reg;
        end
        match   = (l_open < r_close) ? l_open : r_close;
        p_open  = l_open - match + r_open;
        p_close = l_close + r_close - match;
    end

    always_comb
    begin
        mem_we = cmd.clear_wr || cmd.leaf_wr || cmd.merge_wr;
        mem_wa = clr_cnt_reg;
        mem_wd = '0;
        if (cmd.leaf_wr)
        begin
            mem_wa = idx_reg;
            mem_wd = {leaf_open, leaf_close};
        end
        else if (cmd.merge_wr)
        begin
            mem_wa = parent_idx;
            mem_wd = {p_open, p_close};
        end
        mem_ra = cmd.sib_rd ? {idx_reg[AW-1:1], ~idx_reg[0]} : idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.leaf_rd || cmd.sib_rd)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_data;
            idx_reg  <= leaf_idx;
        end
        else if (cmd.merge_wr)
        begin
            idx_reg <= parent_idx;
        end
        if (cmd.leaf_wr)
        begin
            cur_open_reg  <= leaf_open;
            cur_close_reg <= leaf_close;
        end
        else if (cmd.merge_wr)
        begin
            cur_open_reg  <= p_open;
            cur_close_reg <= p_close;
        end
        if (cmd.load_result)
        begin
            result_reg.balanced        <= (root_open_reg == '0) && (root_close_reg == '0);
            result_reg.unmatched_open  <= COUNT_W'(root_open_reg);
            result_reg.unmatched_close <= COUNT_W'(root_close_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            root_open_reg  <= '0;
            root_close_reg <= '0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.merge_wr && status.at_top)
            begin
                root_open_reg  <= p_open;
                root_close_reg <= p_close;
            end
        end
    end

    assign out_data = result_reg;

endmodule

// File: sv/bracket_balance_segment_tree_unit.sv
// Top level of the bracket balance segment tree unit.
// Joins the controller and the datapath; depends on bbst_pkg, bbst_ctrl, bbst_dpath.
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------
//   in      | in_valid / in_ready    | in_data: cmd, position, bracket_kind
//   out     | out_valid / out_ready  | out_data: balanced, unmatched_open/close
//
// An item with a position in range goes from acceptance to result through a leaf read and
// write, then one sibling read and one parent write per tree level through the single node
// memory port pair.
// An out-of-range position skips the tree walk and returns the current root counts.
// After reset a clearing pass writes all 2*SPAN node entries, one a cycle, before in_ready rises.
// A waiting result holds the next one in its final state until out_ready frees the register.
module bracket_balance_segment_tree_unit #(
    parameter int LEAVES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bbst_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output bbst_pkg::out_item_t out_data
);
    import bbst_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    bbst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bbst_dpath #(
        .LEAVES (LEAVES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule
